[src/wps_pkg.sv]
// ----------------------------------------------------------------------------
// Pixel serializer package
// Shared types, command and status codes, register indexes and helpers.
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int unsigned MaxPixels    = 256;
  localparam int unsigned PixAddrW     = $clog2(MaxPixels);
  localparam int unsigned PixCntW      = PixAddrW + 1;
  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned BitPosW      = $clog2(BitsPerPixel);
  localparam int unsigned TicksW       = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;

  typedef logic [BitsPerPixel-1:0] pixel_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_FILL = 2'd2,
    CMD_SHOW = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_BUSY  = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgLedCount  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgZeroHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgZeroLow   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOneHigh   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOneLow    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLatch     = 3'd5;

  // Register values after reset.
  localparam logic [PixCntW-1:0] RstLedCount = 9'd1;
  localparam logic [7:0]         RstZeroHigh = 8'd3;
  localparam logic [7:0]         RstZeroLow  = 8'd9;
  localparam logic [7:0]         RstOneHigh  = 8'd9;
  localparam logic [7:0]         RstOneLow   = 8'd3;
  localparam logic [TicksW-1:0]  RstLatch    = 16'd500;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_FILL     = 7'b0000010,
    ST_LOAD_RD  = 7'b0000100,
    ST_LOAD_SET = 7'b0001000,
    ST_HIGH     = 7'b0010000,
    ST_LOW      = 7'b0100000,
    ST_LATCH    = 7'b1000000
  } state_e;

  // A bit duration of zero behaves as one tick.
  function automatic logic [TicksW-1:0] bit_ticks(input logic [7:0] v);
    logic [TicksW-1:0] r;
    r = (v == 8'd0) ? TicksW'(1) : TicksW'(v);
    return r;
  endfunction

  function automatic logic [TicksW-1:0] latch_len(input logic [TicksW-1:0] v);
    logic [TicksW-1:0] r;
    r = (v == '0) ? TicksW'(1) : v;
    return r;
  endfunction

endpackage

[src/ws2812_pixel_serializer_unit.sv]
// Output: each result is registered and sits in the output register until it is taken.
// Throughput: tick and set-pixel beats go one per cycle while the output is not held;
// a fill holds off input while it writes each pixel in use (one pixel-store write per
// cycle), and a start-frame beat holds off input while the first pixel is read from the store.
// Reset: asynchronous; the per-entry valid bits clear at once, so the store reads
// as all zero without a clearing pass.
// ----------------------------------------------------------------------------
// WS2812 pixel serializer
// Pixel store with set and fill commands, and a bit-serial line encoder that
// emits one line level per tick beat.
// ----------------------------------------------------------------------------
module ws2812_pixel_serializer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [wps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wps_pkg::CfgDataW-1:0]  cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [7:0]                    pixel_index_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic                          line_level_o,
  output logic                          sending_o,
  output logic                          frame_done_o
);
  import wps_pkg::*;

  // Configuration registers.
  logic [PixCntW-1:0] strip_len_q;
  logic [7:0]         zero_high_q, zero_low_q, one_high_q, one_low_q;
  logic [TicksW-1:0]  latch_q;

  // Sequencer and frame state.
  state_e              state_q, state_d;
  logic [PixCntW-1:0]  pos_q, pos_d;
  logic [BitPosW-1:0]  bit_q, bit_d;
  logic [TicksW-1:0]   left_q, left_d;
  pixel_t              shift_q, shift_d;
  pixel_t              fill_q, fill_d;
  logic [PixCntW-1:0]  fill_idx_q, fill_idx_d;
  logic [PixCntW-1:0]  fill_last_q, fill_last_d;

  // Pixel store.
  pixel_t              pix_mem [MaxPixels];
  logic [MaxPixels-1:0] pix_vld_q;
  pixel_t              rd_q;
  logic                vld_rd_q;
  logic [PixAddrW-1:0] rd_addr;
  logic                mem_we;
  logic [PixAddrW-1:0] mem_addr;
  pixel_t              mem_wdata;
  pixel_t              pref;

  // Output register.
  logic                out_valid_q, out_valid_d;
  status_e             status_q, status_d;
  logic                level_q, level_d;
  logic                sending_q, sending_d;
  logic                done_q, done_d;

  logic                in_acc;
  logic                can_take;
  logic [PixCntW-1:0]  n_use;
  logic [TicksW-1:0]   cnt_dec;
  logic                phase_end;
  logic                next_bit;
  logic                pixel_end;
  logic [PixCntW-1:0]  pos_nx;
  pixel_t              grb;
  cmd_e                cmd;

  assign cmd = cmd_e'(cmd_i);
  assign grb = {green_i, red_i, blue_i};

  // Effective pixel count, clamped to 1..MaxPixels.
  always_comb begin
    if (strip_len_q == '0) begin
      n_use = PixCntW'(1);
    end else if (strip_len_q > PixCntW'(MaxPixels)) begin
      n_use = PixCntW'(MaxPixels);
    end else begin
      n_use = strip_len_q;
    end
  end

  // Input is taken only from states that answer at once, and when the output
  // register is free or being emptied this cycle.
  assign can_take   = (state_q == ST_IDLE) || (state_q == ST_HIGH) ||
                      (state_q == ST_LOW) || (state_q == ST_LATCH);
  assign in_stall_o = !can_take || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // The next pixel is prefetched while the current one shifts out; the store
  // cannot change during a frame since commands are refused then.
  assign rd_addr = (state_q == ST_LOAD_RD) ? '0 : (pos_q[PixAddrW-1:0] + PixAddrW'(1));
  assign pref    = vld_rd_q ? rd_q : '0;

  assign cnt_dec   = (left_q != '0) ? (left_q - TicksW'(1)) : left_q;
  assign phase_end = (cnt_dec == '0);
  assign pixel_end = (bit_q == BitPosW'(BitsPerPixel - 1));
  assign pos_nx    = pos_q + PixCntW'(1);
  assign next_bit  = pixel_end ? pref[BitsPerPixel-1] : shift_q[BitsPerPixel-2];

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    bit_d       = bit_q;
    left_d      = left_q;
    shift_d     = shift_q;
    fill_d      = fill_q;
    fill_idx_d  = fill_idx_q;
    fill_last_d = fill_last_q;
    mem_we      = 1'b0;
    mem_addr    = pixel_index_i;
    mem_wdata   = grb;
    status_d    = status_q;
    level_d     = level_q;
    sending_d   = sending_q;
    done_d      = done_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    if (in_acc) begin
      out_valid_d = 1'b1;
      status_d    = STAT_OK;
      level_d     = 1'b0;
      sending_d   = 1'b0;
      done_d      = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_TICK: begin
            end
            CMD_SET: begin
              if ({1'b0, pixel_index_i} >= n_use) begin
                status_d = STAT_RANGE;
              end else begin
                mem_we = 1'b1;
              end
            end
            CMD_FILL: begin
              fill_d      = grb;
              fill_idx_d  = '0;
              fill_last_d = n_use - PixCntW'(1);
              state_d     = ST_FILL;
            end
            CMD_SHOW: begin
              sending_d = 1'b1;
              pos_d     = '0;
              bit_d     = '0;
              state_d   = ST_LOAD_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_we     = 1'b1;
        mem_addr   = fill_idx_q[PixAddrW-1:0];
        mem_wdata  = fill_q;
        fill_idx_d = fill_idx_q + PixCntW'(1);
        if (fill_idx_q == fill_last_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD_RD: begin
        state_d = ST_LOAD_SET;
      end
      ST_LOAD_SET: begin
        shift_d = pref;
        left_d  = bit_ticks(pref[BitsPerPixel-1] ? one_high_q : zero_high_q);
        state_d = ST_HIGH;
      end
      ST_HIGH, ST_LOW, ST_LATCH: begin
        if (in_acc) begin
          sending_d = 1'b1;
          if (cmd != CMD_TICK) begin
            status_d = STAT_BUSY;
          end else begin
            level_d = (state_q == ST_HIGH);
            left_d  = cnt_dec;
            if (phase_end) begin
              priority if (state_q == ST_HIGH) begin
                state_d = ST_LOW;
                left_d  = bit_ticks(shift_q[BitsPerPixel-1] ? one_low_q : zero_low_q);
              end else if (state_q == ST_LOW) begin
                if (pixel_end) begin
                  bit_d   = '0;
                  pos_d   = pos_nx;
                  shift_d = pref;
                end else begin
                  bit_d   = bit_q + BitPosW'(1);
                  shift_d = {shift_q[BitsPerPixel-2:0], 1'b0};
                end
                // A count lowered mid frame ends the data after the current bit.
                if ((pixel_end ? pos_nx : pos_q) >= n_use) begin
                  state_d = ST_LATCH;
                  left_d  = latch_len(latch_q);
                end else begin
                  state_d = ST_HIGH;
                  left_d  = bit_ticks(next_bit ? one_high_q : zero_high_q);
                end
              end else begin
                done_d  = 1'b1;
                state_d = ST_IDLE;
                pos_d   = '0;
                bit_d   = '0;
              end
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_len_q <= RstLedCount;
      zero_high_q <= RstZeroHigh;
      zero_low_q  <= RstZeroLow;
      one_high_q  <= RstOneHigh;
      one_low_q   <= RstOneLow;
      latch_q     <= RstLatch;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLedCount: strip_len_q <= cfg_data_i[PixCntW-1:0];
        CfgZeroHigh: zero_high_q <= cfg_data_i[7:0];
        CfgZeroLow:  zero_low_q  <= cfg_data_i[7:0];
        CfgOneHigh:  one_high_q  <= cfg_data_i[7:0];
        CfgOneLow:   one_low_q   <= cfg_data_i[7:0];
        CfgLatch:    latch_q     <= cfg_data_i[TicksW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      bit_q       <= '0;
      left_q      <= '0;
      fill_idx_q  <= '0;
      fill_last_q <= '0;
      out_valid_q <= 1'b0;
      pix_vld_q   <= '0;
      vld_rd_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      bit_q       <= bit_d;
      left_q      <= left_d;
      fill_idx_q  <= fill_idx_d;
      fill_last_q <= fill_last_d;
      out_valid_q <= out_valid_d;
      vld_rd_q    <= pix_vld_q[rd_addr];
      if (mem_we) begin
        pix_vld_q[mem_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q   <= shift_d;
    fill_q    <= fill_d;
    status_q  <= status_d;
    level_q   <= level_d;
    sending_q <= sending_d;
    done_q    <= done_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pix_mem[mem_addr] <= mem_wdata;
    end
    rd_q <= pix_mem[rd_addr];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign line_level_o = level_q;
  assign sending_o    = sending_q;
  assign frame_done_o = done_q;

  // Sequencer state is always a single hot bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state is not one-hot");

  // The first pixel fetch always completes in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD_RD) |=> (state_q == ST_LOAD_SET))
    else $error("first pixel fetch did not advance");

  // No beat may be taken during a fill sweep or the first pixel fetch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FILL) || (state_q == ST_LOAD_RD) || (state_q == ST_LOAD_SET))
      |-> in_stall_o)
    else $error("input taken while the store is busy");

  // The bit counter never leaves one pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= BitPosW'(BitsPerPixel - 1))
    else $error("bit position out of range");

  // A frame end beat is always reported as part of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (sending_q && (status_q == STAT_OK)))
    else $error("frame end reported outside a frame");

endmodule

[tb/ws2812_pixel_serializer_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WS2812 pixel serializer unit test
// Drives set, fill, start-frame and tick beats through the valid/stall input,
// predicts every result beat from a behavioral copy of the pixel store and the
// bit encoder, and compares each output beat field by field. The run covers
// reset settings, extreme register values, full frames and random traffic
// under several idle and stall mixes.
// ----------------------------------------------------------------------------
module ws2812_pixel_serializer_unit_test;
  import wps_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 300;

  typedef enum logic [1:0] {
    PH_HIGH  = 2'd0,
    PH_LOW   = 2'd1,
    PH_LATCH = 2'd2
  } line_phase_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } beat_in_t;

  typedef struct packed {
    status_e status;
    logic    level;
    logic    sending;
    logic    done;
  } beat_out_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [1:0]          cmd_i         = '0;
  logic [7:0]          pixel_index_i = '0;
  logic [7:0]          red_i         = '0;
  logic [7:0]          green_i       = '0;
  logic [7:0]          blue_i        = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [1:0]          status_o;
  logic                line_level_o;
  logic                sending_o;
  logic                frame_done_o;

  ws2812_pixel_serializer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .pixel_index_i (pixel_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .line_level_o  (line_level_o),
    .sending_o     (sending_o),
    .frame_done_o  (frame_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow registers and encoder state.
  int unsigned c_led, c_zero_high, c_zero_low, c_one_high, c_one_low, c_latch;
  pixel_t      px_store [MaxPixels];
  bit          f_active;
  int unsigned f_pix, f_bit, f_left;
  line_phase_e f_phase;

  beat_in_t    cmd_q [$];
  beat_out_t   want_q [$];
  beat_in_t    drv_beat;

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_req   = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left  = 0;
  int unsigned quiet      = 0;
  int unsigned err_cnt    = 0;

  function automatic int unsigned min1(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned active_count();
    int unsigned c;
    c = min1(c_led);
    return (c > MaxPixels) ? MaxPixels : c;
  endfunction

  function automatic logic bit_now();
    int unsigned p, b;
    p = (f_pix < MaxPixels) ? f_pix : 0;
    b = (f_bit < BitsPerPixel) ? f_bit : 0;
    return px_store[p][BitsPerPixel-1-b];
  endfunction

  function automatic void load_high();
    f_phase = PH_HIGH;
    f_left  = min1(bit_now() ? c_one_high : c_zero_high);
  endfunction

  // Ticks from a start-frame beat until frame_done, for the current store.
  function automatic int unsigned frame_len();
    int unsigned n, len;
    n   = active_count();
    len = min1(c_latch);
    for (int unsigned p = 0; p < n; p++)
      for (int b = 0; b < BitsPerPixel; b++)
        len += px_store[p][b] ? min1(c_one_high) + min1(c_one_low)
                              : min1(c_zero_high) + min1(c_zero_low);
    return len;
  endfunction

  function automatic beat_out_t encoder_step(input beat_in_t it);
    beat_out_t   o;
    int unsigned n;
    pixel_t      grb;
    o.status  = STAT_OK;
    o.level   = 1'b0;
    o.sending = 1'b0;
    o.done    = 1'b0;
    n   = active_count();
    grb = {it.green, it.red, it.blue};
    if (it.cmd == CMD_TICK) begin
      if (f_active) begin
        o.sending = 1'b1;
        o.level   = (f_phase == PH_HIGH);
        if (f_left > 0) f_left = f_left - 1;
        if (f_left == 0) begin
          case (f_phase)
            PH_HIGH: begin
              f_phase = PH_LOW;
              f_left  = min1(bit_now() ? c_one_low : c_zero_low);
            end
            PH_LOW: begin
              f_bit = f_bit + 1;
              if (f_bit >= BitsPerPixel) begin
                f_bit = 0;
                f_pix = f_pix + 1;
              end
              if (f_pix >= n) begin
                f_phase = PH_LATCH;
                f_left  = min1(c_latch);
              end else begin
                load_high();
              end
            end
            default: begin
              o.done   = 1'b1;
              f_active = 1'b0;
              f_pix    = 0;
              f_bit    = 0;
              f_phase  = PH_HIGH;
            end
          endcase
        end
      end
    end else if (f_active) begin
      o.status  = STAT_BUSY;
      o.sending = 1'b1;
    end else if (it.cmd == CMD_SET) begin
      if (it.idx >= n) o.status = STAT_RANGE;
      else px_store[it.idx] = grb;
    end else if (it.cmd == CMD_FILL) begin
      for (int unsigned i = 0; i < n; i++) px_store[i] = grb;
    end else begin
      f_active  = 1'b1;
      f_pix     = 0;
      f_bit     = 0;
      load_high();
      o.sending = 1'b1;
    end
    return o;
  endfunction

  // Driver: a beat is predicted at the edge where it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) want_q.push_back(encoder_step(drv_beat));
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drv_beat = cmd_q.pop_front();
          in_valid_i    <= 1'b1;
          cmd_i         <= drv_beat.cmd;
          pixel_index_i <= drv_beat.idx;
          red_i         <= drv_beat.red;
          green_i       <= drv_beat.green;
          blue_i        <= drv_beat.blue;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk_i) begin : monitor
    beat_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (want_q.size() == 0) begin
          $error("result beat with nothing expected");
          err_cnt++;
        end else begin
          want = want_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            err_cnt++;
          end
          if (line_level_o !== want.level) begin
            $error("line_level: expected %0d, got %0d", want.level, line_level_o);
            err_cnt++;
          end
          if (sending_o !== want.sending) begin
            $error("sending: expected %0d, got %0d", want.sending, sending_o);
            err_cnt++;
          end
          if (frame_done_o !== want.done) begin
            $error("frame_done: expected %0d, got %0d", want.done, frame_done_o);
            err_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (hold_req != hold_taken) begin
        hold_taken  <= hold_req;
        hold_left   <= HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic queue_cmd(input cmd_e c, input logic [7:0] idx, input pixel_t grb);
    beat_in_t b;
    b.cmd   = c;
    b.idx   = idx;
    b.green = grb[23:16];
    b.red   = grb[15:8];
    b.blue  = grb[7:0];
    cmd_q.push_back(b);
  endtask

  task automatic queue_tick();
    queue_cmd(CMD_TICK, 8'($urandom), 24'($urandom));
  endtask

  // Waits until every queued beat is taken and every result has arrived.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || want_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    logic [CfgDataW-1:0] mask, word;
    case (idx)
      CfgLedCount: mask = 16'h01FF;
      CfgLatch:    mask = 16'hFFFF;
      default:     mask = 16'h00FF;
    endcase
    word = CfgDataW'(val) & mask;
    // Bits above the register width must be ignored.
    if ($urandom_range(1) == 1) word = word | (~mask & CfgDataW'($urandom));
    wait_quiet();
    repeat (3) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgLedCount: c_led       = int'(word & mask);
      CfgZeroHigh: c_zero_high = int'(word & mask);
      CfgZeroLow:  c_zero_low  = int'(word & mask);
      CfgOneHigh:  c_one_high  = int'(word & mask);
      CfgOneLow:   c_one_low   = int'(word & mask);
      default:     c_latch     = int'(word & mask);
    endcase
  endtask

  task automatic cfg_all(input int unsigned led, input int unsigned zh, input int unsigned zl,
                         input int unsigned oh, input int unsigned ol, input int unsigned lt);
    cfg_write(CfgLedCount, led);
    cfg_write(CfgZeroHigh, zh);
    cfg_write(CfgZeroLow, zl);
    cfg_write(CfgOneHigh, oh);
    cfg_write(CfgOneLow, ol);
    cfg_write(CfgLatch, lt);
  endtask

  // A whole frame: start beat, exactly enough ticks, then one idle tick.
  // Commands mixed into the frame must all come back busy.
  task automatic run_frame(input int unsigned noise_pct, input bit probe);
    int unsigned len;
    wait_quiet();
    len = frame_len();
    queue_cmd(CMD_SHOW, 8'($urandom), 24'($urandom));
    if (probe) begin
      queue_cmd(CMD_SET, 8'd0, 24'($urandom));
      queue_cmd(CMD_FILL, 8'($urandom), 24'($urandom));
      queue_cmd(CMD_SHOW, 8'($urandom), 24'($urandom));
    end
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(99) < noise_pct)
        queue_cmd(cmd_e'($urandom_range(1, 3)), 8'($urandom), 24'($urandom));
      queue_tick();
    end
    queue_tick();
  endtask

  function automatic int unsigned short_ticks();
    return ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 2);
  endfunction

  task automatic rand_round();
    int unsigned n, k;
    n = ($urandom_range(9) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
    cfg_write(CfgLedCount, n);
    cfg_write(CfgZeroHigh, short_ticks());
    cfg_write(CfgZeroLow, short_ticks());
    cfg_write(CfgOneHigh, short_ticks());
    cfg_write(CfgOneLow, short_ticks());
    cfg_write(CfgLatch, ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 20));
    repeat ($urandom_range(4, 10)) begin
      k = $urandom_range(9);
      if (k < 6)
        queue_cmd(CMD_SET, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(n - 1)),
                  24'($urandom));
      else if (k < 8)
        queue_cmd(CMD_FILL, 8'($urandom), 24'($urandom));
      else
        queue_tick();
    end
    run_frame(($urandom_range(3) == 0) ? 0 : 8, 1'b0);
  endtask

  initial begin : stimulus
    c_led       = RstLedCount;
    c_zero_high = RstZeroHigh;
    c_zero_low  = RstZeroLow;
    c_one_high  = RstOneHigh;
    c_one_low   = RstOneLow;
    c_latch     = RstLatch;
    for (int i = 0; i < MaxPixels; i++) px_store[i] = '0;
    f_active = 1'b0;
    f_pix    = 0;
    f_bit    = 0;
    f_left   = 0;
    f_phase  = PH_HIGH;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset register values: one pixel, default bit timing and latch.
    queue_tick();
    queue_cmd(CMD_SET, 8'd1, 24'h123456);
    queue_cmd(CMD_SET, 8'd255, 24'hFFFFFF);
    queue_cmd(CMD_FILL, 8'd0, 24'h000000);
    queue_cmd(CMD_SET, 8'd0, 24'hFFFFFF);
    queue_cmd(CMD_SET, 8'd0, 24'hA50F3C);
    run_frame(0, 1'b1);

    // Largest strip with the shortest timing: a full fill and the last entry.
    cfg_all(256, 1, 1, 1, 1, 1);
    queue_cmd(CMD_FILL, 8'($urandom), 24'($urandom));
    queue_cmd(CMD_SET, 8'd255, 24'h000000);
    queue_cmd(CMD_SET, 8'd0, 24'hFFFFFF);

    // A short frame over the first two entries with the same timing.
    cfg_write(CfgLedCount, 2);
    queue_cmd(CMD_SET, 8'd255, 24'($urandom));
    run_frame(0, 1'b0);

    // Zero register values behave as one; a long one bit.
    cfg_all(0, 0, 0, 255, 0, 0);
    queue_cmd(CMD_SET, 8'd0, 24'h000001);
    queue_cmd(CMD_SET, 8'd1, 24'($urandom));
    run_frame(0, 1'b0);

    // A count above the store size is clamped.
    cfg_write(CfgLedCount, 511);
    queue_cmd(CMD_SET, 8'd200, 24'($urandom));
    queue_cmd(CMD_FILL, 8'($urandom), 24'($urandom));
    queue_cmd(CMD_SET, 8'd255, 24'($urandom));

    // The receiver holds off while the sender keeps offering beats.
    cfg_all(2, 2, 1, 1, 2, 4);
    wait_quiet();
    hold_req++;
    repeat (40) begin
      if ($urandom_range(1) == 0) queue_tick();
      else queue_cmd(CMD_SET, 8'($urandom_range(5)), 24'($urandom));
    end
    run_frame(5, 1'b0);

    for (int mode = 0; mode < 4; mode++) begin
      wait_quiet();
      case (mode)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 65; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      rand_round();
    end

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && want_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
